@@ src/lda_gibbs_topic_sampler_macros.svh @@
// Assertion macros for the topic sampler.
// Included by the top level; no other dependencies.
`ifndef LDA_GIBBS_TOPIC_SAMPLER_MACROS_SVH
`define LDA_GIBBS_TOPIC_SAMPLER_MACROS_SVH
`ifndef SYNTHESIS
`define LGTS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`define LGTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LGTS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define LGTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ src/lgts_pkg.sv @@
// Shared constants, types and controller/datapath interface structs
// for the topic sampler. No dependencies.
package lgts_pkg;

    localparam int MAX_TOPICS         = 64;
    localparam int MAX_WORDS          = 4096;
    localparam int MAX_DOCS           = 256;
    localparam int MAX_TOKENS_PER_DOC = 1024;
    localparam int COUNT_BITS         = 20;

    localparam int DT_BITS   = 16;
    localparam int TT_BITS   = 24;
    localparam int DS_BITS   = 16;
    localparam int FRAC_BITS = 16;

    localparam int CMD_W      = 1;
    localparam int DOC_IDX_W  = 8;
    localparam int SLOT_IDX_W = 10;
    localparam int WORD_IDX_W = 12;
    localparam int RAND_W     = 32;
    localparam int TOPIC_W    = 6;
    localparam int TC_W       = 7;
    localparam int PRIOR_W    = 32;
    localparam int VOCAB_W    = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int TOPIC_BITS = $clog2(MAX_TOPICS);
    localparam int WORD_BITS  = $clog2(MAX_WORDS);
    localparam int DOC_BITS   = $clog2(MAX_DOCS);
    localparam int SLOT_BITS  = $clog2(MAX_TOKENS_PER_DOC);
    localparam int KE_W       = TOPIC_BITS + 1;

    localparam int WT_AW  = WORD_BITS + TOPIC_BITS;
    localparam int DT_AW  = DOC_BITS + TOPIC_BITS;
    localparam int TOK_AW = DOC_BITS + SLOT_BITS;
    localparam int CLR_AW = ((WORD_BITS > DOC_BITS) ? WORD_BITS : DOC_BITS) + TOPIC_BITS;

    localparam int MUL_W = 32;
    localparam int A_W   = ((COUNT_BITS + FRAC_BITS > PRIOR_W) ?
                            COUNT_BITS + FRAC_BITS : PRIOR_W) + 1;
    localparam int B_W   = ((DT_BITS + FRAC_BITS > PRIOR_W) ?
                            DT_BITS + FRAC_BITS : PRIOR_W) + 1;
    localparam int P_W   = A_W + B_W;
    localparam int VB_W  = VOCAB_W + PRIOR_W;
    localparam int DEN_W = ((TT_BITS + FRAC_BITS > VB_W) ? TT_BITS + FRAC_BITS : VB_W) + 1;
    localparam int Q_W   = 48;
    localparam int QC_W  = $clog2(Q_W);
    localparam int CUM_W = Q_W + TOPIC_BITS;

    localparam logic [TC_W-1:0]    TOPIC_COUNT_RST = TC_W'(8);
    localparam logic [PRIOR_W-1:0] ALPHA_RST       = PRIOR_W'(409600);
    localparam logic [PRIOR_W-1:0] BETA_RST        = PRIOR_W'(655);
    localparam logic [VOCAB_W-1:0] VOCAB_RST       = VOCAB_W'(4096);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOPIC_COUNT = 2'd0,
        CFG_ALPHA       = 2'd1,
        CFG_BETA        = 2'd2,
        CFG_VOCAB       = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        MUL_AB    = 2'd0,
        MUL_RK    = 2'd1,
        MUL_RT_LO = 2'd2,
        MUL_RT_HI = 2'd3
    } t_mul_op;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_INIT_PICK,
        S_TOK_LAT,
        S_DEC_RD,
        S_DEC_WR,
        S_W_RD,
        S_W_OP,
        S_W_M1,
        S_W_M2,
        S_W_DIVS,
        S_W_DIV,
        S_W_ACC,
        S_T_M1,
        S_T_M2,
        S_T_U,
        S_S_RD,
        S_S_CMP,
        S_UPD_RD,
        S_UPD_WR
    } t_state;

    typedef struct packed {
        logic    clr_en;
        logic    load;
        logic    tok_lat;
        logic    cnt_wr;
        logic    cnt_up;
        logic    w_rd;
        logic    w_op;
        logic    mul_en;
        t_mul_op mul_op;
        logic    prod_en;
        logic    div_start;
        logic    acc_en;
        logic    t_clr;
        logic    t_inc;
        logic    tot_clr;
        logic    plo_en;
        logic    u_en;
        logic    pick;
        logic    init_pick;
        logic    result;
    } t_ctrl_cmd;

    typedef struct packed {
        logic clr_last;
        logic resample;
        logic t_last;
        logic div_done;
        logic total_zero;
        logic found;
    } t_dp_status;

endpackage

@@ src/lda_gibbs_topic_sampler.sv @@
// Collapsed Gibbs topic sampler top level. An init request goes through the dispatch,
// init-pick and count-update states before its topic strobes; a resample request
// weighs each of the K topics in use with the one-bit-per-cycle divider, then draws
// a topic from the weights. One request is in flight at a time; busy is high until its
// result strobe. After reset a clearing pass zeroes the count memories with busy high.
// Depends on lgts_pkg, lgts_ctrl, lgts_dpath and the assertion macro header.
`include "lda_gibbs_topic_sampler_macros.svh"
module lda_gibbs_topic_sampler
    import lgts_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  start,
    output logic                  busy,
    input  logic [CMD_W-1:0]      i_command,
    input  logic [DOC_IDX_W-1:0]  i_doc_index,
    input  logic [SLOT_IDX_W-1:0] i_token_slot,
    input  logic [WORD_IDX_W-1:0] i_word_index,
    input  logic [RAND_W-1:0]     i_random_value,
    output logic                  o_topic_valid,
    output logic [TOPIC_W-1:0]    o_topic
);

    t_ctrl_cmd  cmd;
    t_dp_status status;

    lgts_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    lgts_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_command      (i_command),
        .i_doc_index    (i_doc_index),
        .i_token_slot   (i_token_slot),
        .i_word_index   (i_word_index),
        .i_random_value (i_random_value),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_topic        (o_topic)
    );

    assign o_topic_valid = cmd.result;

    `LGTS_ASSERT_IMPLY(a_result_while_busy, i_clk, i_rst_n, o_topic_valid, busy, "result outside a request")
    `LGTS_ASSERT_NEXT(a_accept_sets_busy, i_clk, i_rst_n, start && !busy, busy, "accepted request not busy")
    `LGTS_ASSERT_NEXT(a_result_ends_request, i_clk, i_rst_n, o_topic_valid, !busy && !o_topic_valid, "request did not end after result")
    `LGTS_ASSERT_NEXT(a_div_start_done, i_clk, i_rst_n, cmd.div_start, !cmd.acc_en, "accumulate before divide")

endmodule

@@ src/lgts_div.sv @@
// Restoring divider producing one quotient bit per cycle, saturating at Q_W bits.
// Depends on lgts_pkg.
module lgts_div
    import lgts_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [P_W-1:0]   i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [Q_W-1:0]   o_quot
);

    logic             r_busy;
    logic             r_done;
    logic [QC_W-1:0]  r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [Q_W-1:0]   r_lo;
    logic [Q_W-1:0]   r_q;
    logic [DEN_W:0]   trial;
    logic             fits;
    logic             ovf;

    assign trial = {r_rem, r_lo[Q_W-1]};
    assign fits  = trial >= {1'b0, r_den};
    assign ovf   = (i_num >> Q_W) >= P_W'(i_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= !ovf;
            r_done <= ovf;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_cnt == QC_W'(Q_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_cnt  <= r_cnt + 1'b1;
                r_done <= 1'b0;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= DEN_W'(i_num >> Q_W);
            r_lo  <= i_num[Q_W-1:0];
            r_q   <= ovf ? '1 : '0;
        end else if (r_busy) begin
            r_rem <= fits ? DEN_W'(trial - {1'b0, r_den}) : DEN_W'(trial);
            r_lo  <= r_lo << 1;
            r_q   <= {r_q[Q_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

@@ src/lgts_dpath.sv @@
// Datapath: configuration registers, count and token memories, shared
// multiplier, weight accumulation and search. Depends on lgts_pkg and lgts_div.
module lgts_dpath
    import lgts_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [CMD_W-1:0]      i_command,
    input  logic [DOC_IDX_W-1:0]  i_doc_index,
    input  logic [SLOT_IDX_W-1:0] i_token_slot,
    input  logic [WORD_IDX_W-1:0] i_word_index,
    input  logic [RAND_W-1:0]     i_random_value,
    input  t_ctrl_cmd             i_cmd,
    output t_dp_status            o_status,
    output logic [TOPIC_W-1:0]    o_topic
);

    logic [COUNT_BITS-1:0] m_wt  [MAX_WORDS*MAX_TOPICS];
    logic [DT_BITS-1:0]    m_dt  [MAX_DOCS*MAX_TOPICS];
    logic [TT_BITS-1:0]    m_tt  [MAX_TOPICS];
    logic [DS_BITS-1:0]    m_ds  [MAX_DOCS];
    logic [TOPIC_W-1:0]    m_tok [MAX_DOCS*MAX_TOKENS_PER_DOC];
    logic [CUM_W-1:0]      m_cum [MAX_TOPICS];

    logic [TC_W-1:0]       r_topic_count;
    logic [PRIOR_W-1:0]    r_alpha;
    logic [PRIOR_W-1:0]    r_beta;
    logic [VOCAB_W-1:0]    r_vocab;
    logic [VB_W-1:0]       r_vbeta;

    logic [CLR_AW-1:0]     r_clr;
    logic                  r_command;
    logic [DOC_BITS-1:0]   r_doc;
    logic [SLOT_BITS-1:0]  r_slot;
    logic [WORD_BITS-1:0]  r_word;
    logic [RAND_W-1:0]     r_rand;
    logic [TOPIC_BITS-1:0] r_topic;
    logic [TOPIC_BITS-1:0] r_t;

    logic [COUNT_BITS-1:0] r_wt_q;
    logic [DT_BITS-1:0]    r_dt_q;
    logic [TT_BITS-1:0]    r_tt_q;
    logic [DS_BITS-1:0]    r_ds_q;
    logic [TOPIC_W-1:0]    r_tok_q;
    logic [CUM_W-1:0]      r_cum_q;

    logic [A_W-1:0]        r_a;
    logic [B_W-1:0]        r_b;
    logic [DEN_W-1:0]      r_den;
    logic [2*MUL_W-1:0]    r_mul;
    logic [P_W-1:0]        r_prod;
    logic [CUM_W-1:0]      r_total;
    logic [MUL_W-1:0]      r_plo;
    logic [CUM_W-1:0]      r_u;

    logic [KE_W-1:0]       ke;
    logic [VOCAB_W-1:0]    veff;
    logic [TOPIC_BITS-1:0] tsel;
    logic [MUL_W-1:0]      mul_x;
    logic [MUL_W-1:0]      mul_y;
    logic [DEN_W-1:0]      n_den;
    logic [P_W-1:0]        n_prod;
    logic [CUM_W-1:0]      n_total;
    logic [COUNT_BITS-1:0] n_wt;
    logic [DT_BITS-1:0]    n_dt;
    logic [TT_BITS-1:0]    n_tt;
    logic [DS_BITS-1:0]    n_ds;
    logic                  div_done;
    logic [Q_W-1:0]        div_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_topic_count <= TOPIC_COUNT_RST;
            r_alpha       <= ALPHA_RST;
            r_beta        <= BETA_RST;
            r_vocab       <= VOCAB_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_TOPIC_COUNT: r_topic_count <= i_cfg_data[TC_W-1:0];
                CFG_ALPHA:       r_alpha       <= i_cfg_data[PRIOR_W-1:0];
                CFG_BETA:        r_beta        <= i_cfg_data[PRIOR_W-1:0];
                CFG_VOCAB:       r_vocab       <= i_cfg_data[VOCAB_W-1:0];
                default:         r_vocab       <= r_vocab;
            endcase
        end
    end

    always_comb begin
        if (r_topic_count == '0) begin
            ke = KE_W'(1);
        end else if (r_topic_count > TC_W'(MAX_TOPICS)) begin
            ke = KE_W'(MAX_TOPICS);
        end else begin
            ke = KE_W'(r_topic_count);
        end
        veff = (r_vocab == '0) ? VOCAB_W'(1) : r_vocab;
    end

    always_ff @(posedge i_clk) begin
        r_vbeta <= VB_W'(veff) * VB_W'(r_beta);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_command <= i_command[0];
            r_doc     <= i_doc_index[DOC_BITS-1:0];
            r_slot    <= i_token_slot[SLOT_BITS-1:0];
            r_word    <= i_word_index[WORD_BITS-1:0];
            r_rand    <= i_random_value;
        end
    end

    assign tsel = i_cmd.w_rd ? r_t : r_topic;

    always_ff @(posedge i_clk) begin
        r_wt_q  <= m_wt[{r_word, tsel}];
        r_dt_q  <= m_dt[{r_doc, tsel}];
        r_tt_q  <= m_tt[tsel];
        r_ds_q  <= m_ds[r_doc];
        r_tok_q <= m_tok[{r_doc, r_slot}];
        r_cum_q <= m_cum[r_t];
    end

    always_comb begin
        if (i_cmd.cnt_up) begin
            n_wt = (r_wt_q == '1) ? r_wt_q : r_wt_q + 1'b1;
            n_dt = (r_dt_q == '1) ? r_dt_q : r_dt_q + 1'b1;
            n_tt = (r_tt_q == '1) ? r_tt_q : r_tt_q + 1'b1;
            n_ds = (r_ds_q == '1) ? r_ds_q : r_ds_q + 1'b1;
        end else begin
            n_wt = (r_wt_q == '0) ? r_wt_q : r_wt_q - 1'b1;
            n_dt = (r_dt_q == '0) ? r_dt_q : r_dt_q - 1'b1;
            n_tt = (r_tt_q == '0) ? r_tt_q : r_tt_q - 1'b1;
            n_ds = (r_ds_q == '0) ? r_ds_q : r_ds_q - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_en) begin
            m_wt[r_clr[WT_AW-1:0]]       <= '0;
            m_dt[r_clr[DT_AW-1:0]]       <= '0;
            m_tt[r_clr[TOPIC_BITS-1:0]]  <= '0;
            m_ds[r_clr[DOC_BITS-1:0]]    <= '0;
        end else if (i_cmd.cnt_wr) begin
            m_wt[{r_word, r_topic}] <= n_wt;
            m_dt[{r_doc, r_topic}]  <= n_dt;
            m_tt[r_topic]           <= n_tt;
            m_ds[r_doc]             <= n_ds;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.result) begin
            m_tok[{r_doc, r_slot}] <= TOPIC_W'(r_topic);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_en) begin
            m_cum[r_t] <= n_total;
        end
    end

    always_comb begin
        n_den = (DEN_W'(r_tt_q) << FRAC_BITS) + DEN_W'(r_vbeta);
        if (n_den == '0) begin
            n_den = DEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.w_op) begin
            r_a   <= (A_W'(r_wt_q) << FRAC_BITS) + A_W'(r_beta);
            r_b   <= (B_W'(r_dt_q) << FRAC_BITS) + B_W'(r_alpha);
            r_den <= n_den;
        end
    end

    always_comb begin
        case (i_cmd.mul_op)
            MUL_AB: begin
                mul_x = r_a[MUL_W-1:0];
                mul_y = r_b[MUL_W-1:0];
            end
            MUL_RK: begin
                mul_x = r_rand;
                mul_y = MUL_W'(ke);
            end
            MUL_RT_LO: begin
                mul_x = r_rand;
                mul_y = r_total[MUL_W-1:0];
            end
            MUL_RT_HI: begin
                mul_x = r_rand;
                mul_y = MUL_W'(r_total[CUM_W-1:MUL_W]);
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_mul <= (2*MUL_W)'(mul_x) * (2*MUL_W)'(mul_y);
        end
    end

    assign n_prod = P_W'(r_mul)
                  + ((P_W'(r_a[A_W-1:MUL_W]) * P_W'(r_b)) << MUL_W)
                  + ((P_W'(r_b[B_W-1:MUL_W]) * P_W'(r_a[MUL_W-1:0])) << MUL_W);

    always_ff @(posedge i_clk) begin
        if (i_cmd.prod_en) begin
            r_prod <= n_prod;
        end
    end

    lgts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_prod),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    assign n_total = r_total + CUM_W'(div_q);

    always_ff @(posedge i_clk) begin
        if (i_cmd.tot_clr) begin
            r_total <= '0;
        end else if (i_cmd.acc_en) begin
            r_total <= n_total;
        end
        if (i_cmd.t_clr) begin
            r_t <= '0;
        end else if (i_cmd.t_inc) begin
            r_t <= r_t + 1'b1;
        end
        if (i_cmd.plo_en) begin
            r_plo <= r_mul[2*MUL_W-1:MUL_W];
        end
        if (i_cmd.u_en) begin
            r_u <= CUM_W'(r_mul + (2*MUL_W)'(r_plo));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tok_lat) begin
            r_topic <= TOPIC_BITS'(r_tok_q);
        end else if (i_cmd.init_pick) begin
            r_topic <= r_mul[MUL_W +: TOPIC_BITS];
        end else if (i_cmd.pick) begin
            r_topic <= r_t;
        end
    end

    assign o_status.clr_last   = (r_clr == '1);
    assign o_status.resample   = r_command;
    assign o_status.t_last     = (r_t == TOPIC_BITS'(ke - 1'b1));
    assign o_status.div_done   = div_done;
    assign o_status.total_zero = (r_total == '0);
    assign o_status.found      = (r_u < r_cum_q);

    assign o_topic = TOPIC_W'(r_topic);

endmodule

@@ src/lgts_ctrl.sv @@
// Controller state machine sequencing the reset clearing pass, initial draws and resampling.
// Depends on lgts_pkg.
module lgts_ctrl
    import lgts_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd,
    output logic       o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_RK;
                n_state = i_status.resample ? S_TOK_LAT : S_INIT_PICK;
            end
            S_INIT_PICK: begin
                o_cmd.init_pick = 1'b1;
                n_state = S_UPD_RD;
            end
            S_TOK_LAT: begin
                o_cmd.tok_lat = 1'b1;
                n_state = S_DEC_RD;
            end
            S_DEC_RD: begin
                n_state = S_DEC_WR;
            end
            S_DEC_WR: begin
                o_cmd.cnt_wr  = 1'b1;
                o_cmd.t_clr   = 1'b1;
                o_cmd.tot_clr = 1'b1;
                n_state = S_W_RD;
            end
            S_W_RD: begin
                o_cmd.w_rd = 1'b1;
                n_state = S_W_OP;
            end
            S_W_OP: begin
                o_cmd.w_op = 1'b1;
                n_state = S_W_M1;
            end
            S_W_M1: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_AB;
                n_state = S_W_M2;
            end
            S_W_M2: begin
                o_cmd.prod_en = 1'b1;
                n_state = S_W_DIVS;
            end
            S_W_DIVS: begin
                o_cmd.div_start = 1'b1;
                n_state = S_W_DIV;
            end
            S_W_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_W_ACC;
                end
            end
            S_W_ACC: begin
                o_cmd.acc_en = 1'b1;
                if (i_status.t_last) begin
                    n_state = S_T_M1;
                end else begin
                    o_cmd.t_inc = 1'b1;
                    n_state = S_W_RD;
                end
            end
            S_T_M1: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_RT_LO;
                n_state = S_T_M2;
            end
            S_T_M2: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_RT_HI;
                o_cmd.plo_en = 1'b1;
                n_state = S_T_U;
            end
            S_T_U: begin
                o_cmd.u_en  = 1'b1;
                o_cmd.t_clr = 1'b1;
                n_state = i_status.total_zero ? S_UPD_RD : S_S_RD;
            end
            S_S_RD: begin
                n_state = S_S_CMP;
            end
            S_S_CMP: begin
                if (i_status.found || i_status.t_last) begin
                    o_cmd.pick = 1'b1;
                    n_state = S_UPD_RD;
                end else begin
                    o_cmd.t_inc = 1'b1;
                    n_state = S_S_RD;
                end
            end
            S_UPD_RD: begin
                n_state = S_UPD_WR;
            end
            S_UPD_WR: begin
                o_cmd.cnt_wr = 1'b1;
                o_cmd.cnt_up = 1'b1;
                o_cmd.result = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
